// ===== src/pbfe_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfe_pkg: shared types and constants of the framed protobuf field encoder
// Item kinds, sequencer states, frame commands and the result record that
// travels between the sequencer, the frame unit and the output register.
// ----------------------------------------------------------------------------
package pbfe_pkg;

	// Default buffer size in bytes.
	localparam int DEF_BUF_BYTES = 1024;

	// Fixed widths of the item and result fields.
	localparam int KIND_W   = 3;
	localparam int ID_W     = 16;
	localparam int FNUM_W   = 29;
	localparam int VALUE_W  = 32;
	localparam int SLEN_W   = 11;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 10;
	localparam int SIZE_W   = 11;
	localparam int DIGIT_W  = 32;
	localparam int FIXED_W  = 4;

	// Framing characters and varint constants.
	localparam logic [BYTE_W-1:0] CHAR_MARK = 8'h3F;
	localparam logic [BYTE_W-1:0] CHAR_HASH = 8'h23;
	localparam logic [BYTE_W-1:0] VARINT_CONT = 8'h80;
	localparam logic [5:0] REPORT_LAST = 6'h3F;
	localparam int HDR_END_POS = 9;

	// Fixed offsets in the report header.
	localparam logic [FIXED_W-1:0] OFS_MARK   = 4'd0;
	localparam logic [FIXED_W-1:0] OFS_HASH_A = 4'd1;
	localparam logic [FIXED_W-1:0] OFS_HASH_B = 4'd2;
	localparam logic [FIXED_W-1:0] OFS_ID_HI  = 4'd3;
	localparam logic [FIXED_W-1:0] OFS_ID_LO  = 4'd4;
	localparam logic [FIXED_W-1:0] OFS_LEN_HI = 4'd5;
	localparam logic [FIXED_W-1:0] OFS_LEN_LO = 4'd8;

	// Protobuf wire types.
	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LEN    = 3'd2;

	typedef enum logic [KIND_W-1:0] {
		KIND_START   = 3'd0,
		KIND_BOOL    = 3'd1,
		KIND_VARINT  = 3'd2,
		KIND_STR_HDR = 3'd3,
		KIND_STR_BYTE = 3'd4,
		KIND_END     = 3'd5
	} kind_e;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR,
		ST_KEY,
		ST_VAL,
		ST_MARK,
		ST_LEN,
		ST_NONE
	} state_e;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_FIXED,
		CMD_APPEND,
		CMD_MARK
	} cmd_e;

	typedef enum logic [1:0] {
		DIG_HOLD,
		DIG_LOAD,
		DIG_SHR7,
		DIG_SHL8
	} dig_op_e;

	// One step of work for the frame unit.
	typedef struct packed {
		cmd_e                cmd;
		logic [BYTE_W-1:0]   data;
		logic [FIXED_W-1:0]  ofs;
		logic                clr_ovf;
		logic                set_hdr;
		logic                round_pos;
		logic                last;
	} frame_cmd_t;

	// One result item.
	typedef struct packed {
		logic [ADDR_W-1:0]   write_address;
		logic [BYTE_W-1:0]   write_byte;
		logic                write_valid;
		logic [SIZE_W-1:0]   final_size;
		logic                overflow;
		logic                last;
	} result_t;

endpackage

// ===== src/pbfe_digit_shift.sv =====
// ----------------------------------------------------------------------------
// pbfe_digit_shift: digit shift register
// Holds the value being serialized and hands out one digit per step: seven
// bits from the bottom for varints, eight bits from the top for the length.
// ----------------------------------------------------------------------------
module pbfe_digit_shift (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pbfe_pkg::dig_op_e             op,
	input  logic [pbfe_pkg::DIGIT_W-1:0]  load_val,
	output logic [pbfe_pkg::BYTE_W-1:0]   low8,
	output logic [pbfe_pkg::BYTE_W-1:0]   top8,
	output logic                          more
);
	import pbfe_pkg::*;

	logic [DIGIT_W-1:0] sh_q;

	// Shift one digit per step, or take a new value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= '0;
		end else begin
			unique case (op)
				DIG_LOAD: sh_q <= load_val;
				DIG_SHR7: sh_q <= sh_q >> 7;
				DIG_SHL8: sh_q <= sh_q << 8;
				default:  sh_q <= sh_q;
			endcase
		end
	end

	// A varint needs another group while bits remain above the low seven.
	assign more = |sh_q[DIGIT_W-1:7];
	assign low8 = sh_q[BYTE_W-1:0];
	assign top8 = sh_q[DIGIT_W-1:DIGIT_W-BYTE_W];

endmodule

// ===== src/pbfe_frame.sv =====
// ----------------------------------------------------------------------------
// pbfe_frame: buffer position, payload length and overflow tracking
// Turns one frame command into one result item and keeps the write position,
// the saturating payload length and the sticky overflow flag.
// ----------------------------------------------------------------------------
module pbfe_frame #(
	parameter int BUF_BYTES = pbfe_pkg::DEF_BUF_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  pbfe_pkg::frame_cmd_t          fcmd,
	output pbfe_pkg::result_t             res,
	output logic                          mark_next,
	output logic [pbfe_pkg::DIGIT_W-1:0]  pay_len
);
	import pbfe_pkg::*;

	localparam int PW = $clog2(BUF_BYTES + 127);
	localparam int LW = $clog2(2 * BUF_BYTES);
	localparam logic [PW-1:0] BUF_LIM = PW'(BUF_BYTES);
	localparam logic [LW-1:0] LEN_MAX = LW'(2 * BUF_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic [LW-1:0] len_q;
	logic          ovf_q;

	logic          pos_ok;
	logic [PW-1:0] pos_sum;
	logic [PW-1:0] pos_round;
	logic [PW-1:0] wr_addr;
	logic          is_wr;
	logic          wr_ok;
	logic          ovf_new;
	logic [31:0]   addr_ext;
	logic [31:0]   size_ext;

	// Position checks and the round-up to the next report boundary.
	assign pos_ok    = pos_q < BUF_LIM;
	assign pos_sum   = pos_q + PW'(63);
	assign pos_round = {pos_sum[PW-1:6], 6'd0};
	assign mark_next = pos_ok && (pos_q[5:0] == REPORT_LAST);
	assign pay_len   = DIGIT_W'(len_q);

	// Address and acceptance of the write for this step.
	always_comb begin
		is_wr   = fcmd.cmd != CMD_NONE;
		wr_addr = (fcmd.cmd == CMD_FIXED) ? PW'(fcmd.ofs) : pos_q;
		wr_ok   = (fcmd.cmd == CMD_FIXED) ? 1'b1 : pos_ok;
		ovf_new = (fcmd.clr_ovf ? 1'b0 : ovf_q) | (is_wr && !wr_ok);
	end

	// Result fields; a dropped write shows zero address and byte.
	always_comb begin
		addr_ext          = 32'(wr_addr);
		size_ext          = 32'(pos_round);
		res.write_valid   = is_wr && wr_ok;
		res.write_address = res.write_valid ? addr_ext[ADDR_W-1:0] : '0;
		res.write_byte    = res.write_valid ? fcmd.data : '0;
		res.final_size    = fcmd.round_pos ? size_ext[SIZE_W-1:0] : '0;
		res.overflow      = ovf_new;
		res.last          = fcmd.last;
	end

	// State update on each fired step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			len_q <= '0;
			ovf_q <= 1'b0;
		end else if (fire) begin
			ovf_q <= ovf_new;
			if (fcmd.set_hdr) begin
				pos_q <= PW'(HDR_END_POS);
				len_q <= '0;
			end else if (fcmd.round_pos) begin
				pos_q <= pos_round;
			end else begin
				if ((fcmd.cmd == CMD_APPEND || fcmd.cmd == CMD_MARK) && pos_ok) begin
					pos_q <= pos_q + PW'(1);
				end
				if (fcmd.cmd == CMD_APPEND && len_q < LEN_MAX) begin
					len_q <= len_q + LW'(1);
				end
			end
		end
	end

endmodule

// ===== src/pbfe_out_reg.sv =====
// ----------------------------------------------------------------------------
// pbfe_out_reg: result output register
// Holds one result item until the consumer takes it, and tells the sequencer
// when a new result may be loaded.
// ----------------------------------------------------------------------------
module pbfe_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pbfe_pkg::result_t   res_in,
	output logic                free,
	output logic                out_valid,
	input  logic                out_stall,
	output pbfe_pkg::result_t   res_out
);
	import pbfe_pkg::*;

	logic    valid_q;
	result_t res_q;

	// The register may be refilled when empty or when its transfer completes.
	assign free      = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// ===== src/protobuf_field_encoder_framed.sv =====
// ----------------------------------------------------------------------------
// protobuf_field_encoder_framed: framed protobuf field encoder
// Serializes message items into 64-byte reports and emits byte writes.
//
//   Channel | Direction | Handshake            | Payload
//   --------+-----------+----------------------+-------------------------------
//   input   | in        | in_valid / in_stall  | kind, msg_id, field_id,
//           |           |                      | value, string_length,
//           |           |                      | string_byte
//   output  | out       | out_valid / out_stall| write_address, write_byte,
//           |           |                      | write_valid, final_size,
//           |           |                      | overflow, last
//
// An item is taken in, then its results, up to 11 of them, leave one at a time
// through the single byte lane of the sequencer. Varints leave the digit shift
// register seven bits per cycle unless out_stall holds a result.
// Reset clears the position, payload length and overflow flag; no pass follows.
// A result held by out_stall stops the sequencer, and in_stall stays high until
// the last result of the item has entered the output register.
// ----------------------------------------------------------------------------
module protobuf_field_encoder_framed #(
	parameter int BUF_BYTES = pbfe_pkg::DEF_BUF_BYTES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pbfe_pkg::KIND_W-1:0]   kind,
	input  logic [pbfe_pkg::ID_W-1:0]     msg_id,
	input  logic [pbfe_pkg::FNUM_W-1:0]   field_id,
	input  logic [pbfe_pkg::VALUE_W-1:0]  value,
	input  logic [pbfe_pkg::SLEN_W-1:0]   string_length,
	input  logic [pbfe_pkg::BYTE_W-1:0]   string_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pbfe_pkg::ADDR_W-1:0]   write_address,
	output logic [pbfe_pkg::BYTE_W-1:0]   write_byte,
	output logic                          write_valid,
	output logic [pbfe_pkg::SIZE_W-1:0]   final_size,
	output logic                          overflow,
	output logic                          last
);
	import pbfe_pkg::*;

	state_e              state_q, state_d;
	state_e              ret_q, ret_d;
	logic [FIXED_W-1:0]  idx_q, idx_d;
	logic [DIGIT_W-1:0]  val_q;
	logic                raw_q;

	logic                accept;
	logic                step;
	logic                fire;
	logic                out_free;
	logic                mark_next;
	logic [DIGIT_W-1:0]  pay_len;
	logic [DIGIT_W-1:0]  load_val;
	logic [DIGIT_W-1:0]  key_val;
	dig_op_e             dig_op;
	logic [BYTE_W-1:0]   dig_low8;
	logic [BYTE_W-1:0]   dig_top8;
	logic                dig_more;
	logic [BYTE_W-1:0]   var_byte;
	logic                val_done;
	frame_cmd_t          fcmd;
	result_t             res_new;
	result_t             res_q;

	// Handshake: one item in flight at a time.
	assign in_stall = state_q != ST_IDLE;
	assign accept   = in_valid && !in_stall;
	assign step     = out_free && state_q != ST_IDLE;

	// Varint group of the current digit, with the continuation bit.
	assign var_byte = dig_more ? (VARINT_CONT | {1'b0, dig_low8[6:0]})
	                           : {1'b0, dig_low8[6:0]};
	assign val_done = raw_q || !dig_more;

	// Key of a field item, with its wire type.
	always_comb begin
		key_val = {field_id, WT_VARINT};
		if (kind == KIND_STR_HDR) begin
			key_val = {field_id, WT_LEN};
		end
	end

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		idx_d   = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_START: begin
							state_d = ST_HDR;
							idx_d   = OFS_MARK;
						end
						KIND_BOOL, KIND_VARINT, KIND_STR_HDR: state_d = ST_KEY;
						KIND_STR_BYTE: state_d = ST_VAL;
						KIND_END: begin
							state_d = ST_LEN;
							idx_d   = OFS_LEN_HI;
						end
						default: state_d = ST_NONE;
					endcase
				end
			end
			ST_HDR: begin
				if (step) begin
					idx_d = idx_q + FIXED_W'(1);
					if (idx_q == OFS_ID_LO) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_KEY: begin
				if (step) begin
					if (mark_next) begin
						state_d = ST_MARK;
						ret_d   = dig_more ? ST_KEY : ST_VAL;
					end else if (!dig_more) begin
						state_d = ST_VAL;
					end
				end
			end
			ST_VAL: begin
				if (step) begin
					if (mark_next) begin
						state_d = ST_MARK;
						ret_d   = val_done ? ST_IDLE : ST_VAL;
					end else if (val_done) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_MARK: begin
				if (step) begin
					state_d = ret_q;
				end
			end
			ST_LEN: begin
				if (step) begin
					idx_d = idx_q + FIXED_W'(1);
					if (idx_q == OFS_LEN_LO) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NONE: begin
				if (step) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Sequencer outputs: frame command, digit shift and its load value.
	always_comb begin
		fcmd     = '{cmd: CMD_NONE, data: '0, ofs: idx_q, clr_ovf: 1'b0,
		             set_hdr: 1'b0, round_pos: 1'b0, last: 1'b0};
		fire     = 1'b0;
		dig_op   = DIG_HOLD;
		load_val = val_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dig_op = DIG_LOAD;
				end
				unique case (kind)
					KIND_STR_BYTE: load_val = DIGIT_W'(string_byte);
					KIND_END:      load_val = pay_len;
					default:       load_val = DIGIT_W'(key_val);
				endcase
			end
			ST_HDR: begin
				fire         = step;
				fcmd.cmd     = CMD_FIXED;
				fcmd.clr_ovf = idx_q == OFS_MARK;
				fcmd.set_hdr = idx_q == OFS_ID_LO;
				fcmd.last    = idx_q == OFS_ID_LO;
				unique case (idx_q)
					OFS_MARK:              fcmd.data = CHAR_MARK;
					OFS_HASH_A, OFS_HASH_B: fcmd.data = CHAR_HASH;
					OFS_ID_HI:             fcmd.data = val_q[15:8];
					default:               fcmd.data = val_q[7:0];
				endcase
			end
			ST_KEY: begin
				fire      = step;
				fcmd.cmd  = CMD_APPEND;
				fcmd.data = var_byte;
				if (step) begin
					dig_op = dig_more ? DIG_SHR7 : DIG_LOAD;
				end
			end
			ST_VAL: begin
				fire      = step;
				fcmd.cmd  = CMD_APPEND;
				fcmd.data = raw_q ? dig_low8 : var_byte;
				fcmd.last = val_done && !mark_next;
				if (step) begin
					dig_op = DIG_SHR7;
				end
			end
			ST_MARK: begin
				fire      = step;
				fcmd.cmd  = CMD_MARK;
				fcmd.data = CHAR_MARK;
				fcmd.last = ret_q == ST_IDLE;
			end
			ST_LEN: begin
				fire           = step;
				fcmd.cmd       = CMD_FIXED;
				fcmd.data      = dig_top8;
				fcmd.round_pos = idx_q == OFS_LEN_LO;
				fcmd.last      = idx_q == OFS_LEN_LO;
				if (step) begin
					dig_op = DIG_SHL8;
				end
			end
			ST_NONE: begin
				fire      = step;
				fcmd.last = 1'b1;
			end
			default: begin
				fire = 1'b0;
			end
		endcase
	end

	// Sequencer registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			idx_q   <= '0;
			raw_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			idx_q   <= idx_d;
			if (accept) begin
				raw_q <= kind == KIND_STR_BYTE;
			end
		end
	end

	// Second value of the item: message id, field value, bool or length.
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (kind)
				KIND_START:   val_q <= DIGIT_W'(msg_id);
				KIND_BOOL:    val_q <= DIGIT_W'(value != '0);
				KIND_STR_HDR: val_q <= DIGIT_W'(string_length);
				default:      val_q <= value;
			endcase
		end
	end

	pbfe_digit_shift u_digit (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (dig_op),
		.load_val (load_val),
		.low8     (dig_low8),
		.top8     (dig_top8),
		.more     (dig_more)
	);

	pbfe_frame #(
		.BUF_BYTES (BUF_BYTES)
	) u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.fcmd      (fcmd),
		.res       (res_new),
		.mark_next (mark_next),
		.pay_len   (pay_len)
	);

	pbfe_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res_in    (res_new),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_out   (res_q)
	);

	assign write_address = res_q.write_address;
	assign write_byte    = res_q.write_byte;
	assign write_valid   = res_q.write_valid;
	assign final_size    = res_q.final_size;
	assign overflow      = res_q.overflow;
	assign last          = res_q.last;

	// Every accepted item keeps the input side stalled in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled after a transfer");

	// The aligned size comes only on the closing result of an item.
	a_size_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && final_size != '0 |-> last)
		else $error("final size on a result that is not last");

	// The aligned size sits on a report boundary.
	a_size_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> final_size[5:0] == 6'd0)
		else $error("final size not on a report boundary");

	// A result without a write carries neither address nor byte.
	a_dropped_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_valid |-> write_address == '0 && write_byte == '0)
		else $error("result without a write carries data");

endmodule
